// ===== src/coap_pkg.sv =====
// ----------------------------------------------------------------------------
// coap_pkg
// Shared types and constants for the CoAP message parser: parse phases,
// byte classes, status codes and option encoding constants.
// ----------------------------------------------------------------------------
package coap_pkg;

   typedef enum logic [2:0] {
      PH_HEADER    = 3'd0,
      PH_TOKEN     = 3'd1,
      PH_OPT_HEAD  = 3'd2,
      PH_DELTA_EXT = 3'd3,
      PH_LEN_EXT   = 3'd4,
      PH_VALUE     = 3'd5,
      PH_PAYLOAD   = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      KIND_HEADER  = 3'd0,
      KIND_TOKEN   = 3'd1,
      KIND_OPTHEAD = 3'd2,
      KIND_VALUE   = 3'd3,
      KIND_MARKER  = 3'd4,
      KIND_PAYLOAD = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_VERSION   = 3'd1,
      ST_RESERVED  = 3'd2,
      ST_TRUNCATED = 3'd3,
      ST_OVERFLOW  = 3'd4
   } status_type;

   localparam logic [1:0]  VERSION_RESET  = 2'd1;
   localparam logic [7:0]  PAYLOAD_MARKER = 8'hff;
   localparam logic [3:0]  NIB_EXT8       = 4'd13;
   localparam logic [3:0]  NIB_EXT16      = 4'd14;
   localparam logic [3:0]  NIB_RESERVED   = 4'd15;
   localparam logic [16:0] EXT8_BASE      = 17'd13;
   localparam logic [16:0] EXT16_BASE     = 17'd269;
   localparam logic [15:0] OPTION_MAX     = 16'hffff;

endpackage

// ===== src/coap_message_parser.sv =====
// An accepted item passes through the input register and then the result register to rsp_valid.
// Throughput: one item per cycle while rsp_ready is high; ready follows it via both registers.
// The parse state advances once per item as it moves from the input to the result register.
// Reset (synchronous, active high) empties both registers, returns the parser to the header
// phase with no latched error, clears the header fields and sets the expected version to 1.
// ----------------------------------------------------------------------------
// coap_message_parser
// Streaming CoAP message parser: classifies each byte, decodes the header
// and option heads, and reports the first error on the last byte.
// ----------------------------------------------------------------------------
module coap_message_parser
   import coap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_byte_out,
   output logic [2:0]  rsp_byte_kind,
   output logic        rsp_option_ready,
   output logic [15:0] rsp_option_number,
   output logic [16:0] rsp_option_length,
   output logic        rsp_header_ready,
   output logic [1:0]  rsp_message_type,
   output logic [3:0]  rsp_token_length,
   output logic [7:0]  rsp_request_code,
   output logic [15:0] rsp_message_id,
   output logic        rsp_end_of_message,
   output logic [2:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        out_free;
   logic        advance;

   logic [1:0]  version_ff;

   phase_type   phase_ff, phase_in;
   logic [1:0]  header_index_ff, header_index_in;
   logic [3:0]  token_left_ff, token_left_in;
   logic [1:0]  ext_left_ff, ext_left_in;
   logic [3:0]  delta_ff, delta_in;
   logic [3:0]  length_ff, length_in;
   logic [15:0] ext_accum_ff, ext_accum_in;
   logic [15:0] option_ff, option_in;
   logic [16:0] value_left_ff, value_left_in;
   logic [1:0]  type_ff, type_in;
   logic [3:0]  tkl_ff, tkl_in;
   logic [7:0]  code_ff, code_in;
   logic [15:0] id_ff, id_in;
   status_type  error_ff, error_in;

   logic        rsp_valid_ff;
   logic [7:0]  byte_ff;
   kind_type    kind_ff, kind_in;
   logic        opt_rdy_ff, opt_rdy_in;
   logic [15:0] opt_num_ff, opt_num_in;
   logic [16:0] opt_len_ff, opt_len_in;
   logic        hdr_rdy_ff, hdr_rdy_in;
   logic [1:0]  msg_type_ff, msg_type_in;
   logic [3:0]  tok_len_ff, tok_len_in;
   logic [7:0]  req_code_ff, req_code_in;
   logic [15:0] msg_id_ff, msg_id_in;
   logic        eom_ff;
   status_type  status_ff, status_in;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= VERSION_RESET;
      end else if (csr_wr_en) begin
         version_ff <= csr_wr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   always_comb begin
      logic [17:0] sum;
      logic [16:0] dval;
      logic [16:0] flen;
      logic [15:0] acc;
      logic [3:0]  len_nib;
      logic        do_delta;
      logic        do_finish;

      phase_in        = phase_ff;
      header_index_in = header_index_ff;
      token_left_in   = token_left_ff;
      ext_left_in     = ext_left_ff;
      delta_in        = delta_ff;
      length_in       = length_ff;
      ext_accum_in    = ext_accum_ff;
      option_in       = option_ff;
      value_left_in   = value_left_ff;
      type_in         = type_ff;
      tkl_in          = tkl_ff;
      code_in         = code_ff;
      id_in           = id_ff;
      error_in        = error_ff;
      kind_in         = KIND_HEADER;
      opt_rdy_in      = 1'b0;
      hdr_rdy_in      = 1'b0;
      status_in       = ST_OK;
      sum             = '0;
      dval            = '0;
      flen            = '0;
      len_nib         = '0;
      do_delta        = 1'b0;
      do_finish       = 1'b0;
      acc             = {ext_accum_ff[7:0], in_byte_ff};

      unique case (phase_ff)
         PH_TOKEN: begin
            kind_in       = KIND_TOKEN;
            token_left_in = token_left_ff - 4'd1;
            if (token_left_in == 4'd0) begin
               phase_in = PH_OPT_HEAD;
            end
         end
         PH_OPT_HEAD: begin
            if (in_byte_ff == PAYLOAD_MARKER) begin
               kind_in  = KIND_MARKER;
               phase_in = PH_PAYLOAD;
            end else begin
               kind_in   = KIND_OPTHEAD;
               delta_in  = in_byte_ff[7:4];
               length_in = in_byte_ff[3:0];
               if (in_byte_ff[7:4] == NIB_EXT8 || in_byte_ff[7:4] == NIB_EXT16) begin
                  phase_in     = PH_DELTA_EXT;
                  ext_left_in  = (in_byte_ff[7:4] == NIB_EXT8) ? 2'd1 : 2'd2;
                  ext_accum_in = '0;
               end else begin
                  if (in_byte_ff[7:4] == NIB_RESERVED && error_in == ST_OK) begin
                     error_in = ST_RESERVED;
                  end
                  do_delta = 1'b1;
                  dval     = {13'd0, in_byte_ff[7:4]};
                  len_nib  = in_byte_ff[3:0];
               end
            end
         end
         PH_DELTA_EXT, PH_LEN_EXT: begin
            kind_in      = KIND_OPTHEAD;
            ext_accum_in = acc;
            ext_left_in  = ext_left_ff - 2'd1;
            if (ext_left_in == 2'd0) begin
               if (phase_ff == PH_DELTA_EXT) begin
                  do_delta = 1'b1;
                  dval     = {1'b0, acc} + ((delta_ff == NIB_EXT8) ? EXT8_BASE : EXT16_BASE);
                  len_nib  = length_ff;
               end else begin
                  do_finish = 1'b1;
                  flen = {1'b0, acc} + ((length_ff == NIB_EXT8) ? EXT8_BASE : EXT16_BASE);
               end
            end
         end
         PH_VALUE: begin
            kind_in = KIND_VALUE;
            if (value_left_ff != 17'd0) begin
               value_left_in = value_left_ff - 17'd1;
            end
            if (value_left_in == 17'd0) begin
               phase_in = PH_OPT_HEAD;
            end
         end
         PH_PAYLOAD: begin
            kind_in = KIND_PAYLOAD;
         end
         default: begin
            kind_in = KIND_HEADER;
            unique case (header_index_ff)
               2'd0: begin
                  if (in_byte_ff[7:6] != version_ff && error_in == ST_OK) begin
                     error_in = ST_VERSION;
                  end
                  type_in = in_byte_ff[5:4];
                  tkl_in  = in_byte_ff[3:0];
                  code_in = '0;
                  id_in   = '0;
               end
               2'd1: code_in = in_byte_ff;
               2'd2: id_in[15:8] = in_byte_ff;
               default: begin
                  id_in[7:0] = in_byte_ff;
                  hdr_rdy_in = 1'b1;
               end
            endcase
            if (header_index_ff == 2'd3) begin
               header_index_in = 2'd0;
               token_left_in   = tkl_in;
               phase_in        = (tkl_in != 4'd0) ? PH_TOKEN : PH_OPT_HEAD;
            end else begin
               header_index_in = header_index_ff + 2'd1;
               phase_in        = PH_HEADER;
            end
         end
      endcase

      // add delta, saturate on overflow
      if (do_delta) begin
         sum = {2'b00, option_ff} + {1'b0, dval};
         if (sum > {2'b00, OPTION_MAX}) begin
            if (error_in == ST_OK) begin
               error_in = ST_OVERFLOW;
            end
            option_in = OPTION_MAX;
         end else begin
            option_in = sum[15:0];
         end
         if (len_nib == NIB_EXT8 || len_nib == NIB_EXT16) begin
            phase_in     = PH_LEN_EXT;
            ext_left_in  = (len_nib == NIB_EXT8) ? 2'd1 : 2'd2;
            ext_accum_in = '0;
         end else begin
            if (len_nib == NIB_RESERVED && error_in == ST_OK) begin
               error_in = ST_RESERVED;
            end
            do_finish = 1'b1;
            flen      = {13'd0, len_nib};
         end
      end

      if (do_finish) begin
         opt_rdy_in    = 1'b1;
         value_left_in = flen;
         phase_in      = (flen != 17'd0) ? PH_VALUE : PH_OPT_HEAD;
      end

      opt_num_in  = opt_rdy_in ? option_in : 16'd0;
      opt_len_in  = opt_rdy_in ? flen : 17'd0;
      msg_type_in = hdr_rdy_in ? type_in : 2'd0;
      tok_len_in  = hdr_rdy_in ? tkl_in : 4'd0;
      req_code_in = hdr_rdy_in ? code_in : 8'd0;
      msg_id_in   = hdr_rdy_in ? id_in : 16'd0;

      // end of message: report and drop message state
      if (in_last_ff) begin
         if (phase_in != PH_OPT_HEAD && phase_in != PH_PAYLOAD && error_in == ST_OK) begin
            error_in = ST_TRUNCATED;
         end
         status_in       = error_in;
         phase_in        = PH_HEADER;
         header_index_in = '0;
         token_left_in   = '0;
         ext_left_in     = '0;
         delta_in        = '0;
         length_in       = '0;
         ext_accum_in    = '0;
         option_in       = '0;
         value_left_in   = '0;
         error_in        = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         header_index_ff <= '0;
         token_left_ff   <= '0;
         ext_left_ff     <= '0;
         delta_ff        <= '0;
         length_ff       <= '0;
         ext_accum_ff    <= '0;
         option_ff       <= '0;
         value_left_ff   <= '0;
         type_ff         <= '0;
         tkl_ff          <= '0;
         code_ff         <= '0;
         id_ff           <= '0;
         error_ff        <= ST_OK;
      end else if (advance) begin
         phase_ff        <= phase_in;
         header_index_ff <= header_index_in;
         token_left_ff   <= token_left_in;
         ext_left_ff     <= ext_left_in;
         delta_ff        <= delta_in;
         length_ff       <= length_in;
         ext_accum_ff    <= ext_accum_in;
         option_ff       <= option_in;
         value_left_ff   <= value_left_in;
         type_ff         <= type_in;
         tkl_ff          <= tkl_in;
         code_ff         <= code_in;
         id_ff           <= id_in;
         error_ff        <= error_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff     <= in_byte_ff;
         kind_ff     <= kind_in;
         opt_rdy_ff  <= opt_rdy_in;
         opt_num_ff  <= opt_num_in;
         opt_len_ff  <= opt_len_in;
         hdr_rdy_ff  <= hdr_rdy_in;
         msg_type_ff <= msg_type_in;
         tok_len_ff  <= tok_len_in;
         req_code_ff <= req_code_in;
         msg_id_ff   <= msg_id_in;
         eom_ff      <= in_last_ff;
         status_ff   <= status_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_byte_out       = byte_ff;
   assign rsp_byte_kind      = kind_ff;
   assign rsp_option_ready   = opt_rdy_ff;
   assign rsp_option_number  = opt_num_ff;
   assign rsp_option_length  = opt_len_ff;
   assign rsp_header_ready   = hdr_rdy_ff;
   assign rsp_message_type   = msg_type_ff;
   assign rsp_token_length   = tok_len_ff;
   assign rsp_request_code   = req_code_ff;
   assign rsp_message_id     = msg_id_ff;
   assign rsp_end_of_message = eom_ff;
   assign rsp_status         = status_ff;

   a_hdr_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && hdr_rdy_ff |-> kind_ff == KIND_HEADER)
      else $error("header ready on a non-header item");

   a_opt_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && opt_rdy_ff |-> kind_ff == KIND_OPTHEAD)
      else $error("option ready on a non-option-head item");

   a_status_eom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != ST_OK |-> eom_ff)
      else $error("status reported before end of message");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> phase_ff == PH_HEADER && error_ff == ST_OK
         && header_index_ff == 2'd0)
      else $error("message state not cleared after last item");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("input register overwritten while held");

endmodule
